// File: hdl/ray_triangle_nearest_hit_macros.svh
// Assertion macros for the ray/triangle nearest-hit block.
`ifndef RAY_TRIANGLE_NEAREST_HIT_MACROS_SVH
`define RAY_TRIANGLE_NEAREST_HIT_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define RTNH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define RTNH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RTNH_ASSERT(lbl, prop, msg)
`define RTNH_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hdl/rtnh_pkg.sv
// Shared types, widths and the multiply-accumulate microprogram of the hit tester.
package rtnh_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned ID_BITS_DEF = 16;
  localparam int unsigned CRD_W       = 32;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned BARY_W      = 17;
  localparam int unsigned NW          = CRD_W + 1;   // edge / offset operands
  localparam int unsigned WW          = 2 * NW + 2;  // cross product terms
  localparam int unsigned BW          = 136;         // dot products and scaled limits
  localparam int unsigned DIV_STEPS   = CRD_W;
  localparam int unsigned NUM_REGS    = 8;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned NUM_UOPS    = 26;
  localparam int unsigned STEP_W      = 5;
  localparam int unsigned CNT_W       = 6;

  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic signed [NW-1:0]    nar_t;
  typedef logic signed [WW-1:0]    wid_t;
  typedef logic signed [BW-1:0]    big_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    R_ORG_X = 4'd0, R_ORG_Y = 4'd1, R_ORG_Z = 4'd2,
    R_DIR_X = 4'd3, R_DIR_Y = 4'd4, R_DIR_Z = 4'd5,
    R_T_LOWER = 4'd6, R_T_UPPER = 4'd7
  } reg_e;

  // narrow (multiplier) operand
  typedef enum logic [3:0] {
    N_DIR0 = 4'd0, N_DIR1 = 4'd1, N_DIR2 = 4'd2,
    N_E1_0 = 4'd3, N_E1_1 = 4'd4, N_E1_2 = 4'd5,
    N_E2_0 = 4'd6, N_E2_1 = 4'd7, N_E2_2 = 4'd8,
    N_S0   = 4'd9, N_S1   = 4'd10, N_S2  = 4'd11,
    N_TLO  = 4'd12, N_THI = 4'd13
  } nsel_e;

  // wide (multiplicand) operand
  typedef enum logic [3:0] {
    W_E1_0 = 4'd0, W_E1_1 = 4'd1, W_E1_2 = 4'd2,
    W_E2_0 = 4'd3, W_E2_1 = 4'd4, W_E2_2 = 4'd5,
    W_P0   = 4'd6, W_P1   = 4'd7, W_P2   = 4'd8,
    W_Q0   = 4'd9, W_Q1   = 4'd10, W_Q2  = 4'd11,
    W_DET  = 4'd12
  } wsel_e;

  typedef enum logic [3:0] {
    D_P0 = 4'd0, D_P1 = 4'd1, D_P2 = 4'd2, D_DET = 4'd3,
    D_Q0 = 4'd4, D_Q1 = 4'd5, D_Q2 = 4'd6,
    D_UN = 4'd7, D_VN = 4'd8, D_TN = 4'd9, D_TL = 4'd10, D_TU = 4'd11
  } dest_e;

  typedef struct packed {
    nsel_e nsel;
    wsel_e wsel;
    logic  neg;    // subtract the product
    logic  first;  // clear accumulator
    logic  last;   // write accumulator to dest
    dest_e dest;
  } uop_t;

  localparam logic [STEP_W-1:0] STEP_CHK_DET = 5'd9;   // first step after det
  localparam logic [STEP_W-1:0] STEP_TN_END  = 5'd23;
  localparam logic [STEP_W-1:0] STEP_TU_END  = 5'd25;

  function automatic uop_t mk(input nsel_e n, input wsel_e w, input logic ng,
                              input logic f, input logic l, input dest_e d);
    uop_t u;
    u.nsel  = n;
    u.wsel  = w;
    u.neg   = ng;
    u.first = f;
    u.last  = l;
    u.dest  = d;
    return u;
  endfunction

  function automatic uop_t uop_at(input logic [STEP_W-1:0] idx);
    uop_t u;
    case (idx)
      // p = dir x e2
      5'd0:  u = mk(N_DIR1, W_E2_2, 1'b0, 1'b1, 1'b0, D_P0);
      5'd1:  u = mk(N_DIR2, W_E2_1, 1'b1, 1'b0, 1'b1, D_P0);
      5'd2:  u = mk(N_DIR2, W_E2_0, 1'b0, 1'b1, 1'b0, D_P1);
      5'd3:  u = mk(N_DIR0, W_E2_2, 1'b1, 1'b0, 1'b1, D_P1);
      5'd4:  u = mk(N_DIR0, W_E2_1, 1'b0, 1'b1, 1'b0, D_P2);
      5'd5:  u = mk(N_DIR1, W_E2_0, 1'b1, 1'b0, 1'b1, D_P2);
      // det = e1 . p
      5'd6:  u = mk(N_E1_0, W_P0, 1'b0, 1'b1, 1'b0, D_DET);
      5'd7:  u = mk(N_E1_1, W_P1, 1'b0, 1'b0, 1'b0, D_DET);
      5'd8:  u = mk(N_E1_2, W_P2, 1'b0, 1'b0, 1'b1, D_DET);
      // q = s x e1
      5'd9:  u = mk(N_S1, W_E1_2, 1'b0, 1'b1, 1'b0, D_Q0);
      5'd10: u = mk(N_S2, W_E1_1, 1'b1, 1'b0, 1'b1, D_Q0);
      5'd11: u = mk(N_S2, W_E1_0, 1'b0, 1'b1, 1'b0, D_Q1);
      5'd12: u = mk(N_S0, W_E1_2, 1'b1, 1'b0, 1'b1, D_Q1);
      5'd13: u = mk(N_S0, W_E1_1, 1'b0, 1'b1, 1'b0, D_Q2);
      5'd14: u = mk(N_S1, W_E1_0, 1'b1, 1'b0, 1'b1, D_Q2);
      // u numerator = s . p
      5'd15: u = mk(N_S0, W_P0, 1'b0, 1'b1, 1'b0, D_UN);
      5'd16: u = mk(N_S1, W_P1, 1'b0, 1'b0, 1'b0, D_UN);
      5'd17: u = mk(N_S2, W_P2, 1'b0, 1'b0, 1'b1, D_UN);
      // v numerator = dir . q
      5'd18: u = mk(N_DIR0, W_Q0, 1'b0, 1'b1, 1'b0, D_VN);
      5'd19: u = mk(N_DIR1, W_Q1, 1'b0, 1'b0, 1'b0, D_VN);
      5'd20: u = mk(N_DIR2, W_Q2, 1'b0, 1'b0, 1'b1, D_VN);
      // t numerator = e2 . q
      5'd21: u = mk(N_E2_0, W_Q0, 1'b0, 1'b1, 1'b0, D_TN);
      5'd22: u = mk(N_E2_1, W_Q1, 1'b0, 1'b0, 1'b0, D_TN);
      5'd23: u = mk(N_E2_2, W_Q2, 1'b0, 1'b0, 1'b1, D_TN);
      // distance window scaled by |det|
      5'd24: u = mk(N_TLO, W_DET, 1'b0, 1'b1, 1'b1, D_TL);
      5'd25: u = mk(N_THI, W_DET, 1'b0, 1'b1, 1'b1, D_TU);
      default: u = mk(N_DIR0, W_E1_0, 1'b0, 1'b1, 1'b0, D_P0);
    endcase
    return u;
  endfunction

endpackage

// File: hdl/rtnh_intf.sv
// Channel interfaces: configuration writes, triangle words and result words.
interface rtnh_cfg_if import rtnh_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CRD_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

interface rtnh_tri_if import rtnh_pkg::*;;
  logic            valid;
  logic            ready;
  crd_t            v0_x, v0_y, v0_z;
  crd_t            v1_x, v1_y, v1_z;
  crd_t            v2_x, v2_y, v2_z;
  logic [ID_W-1:0] triangle_id;
  logic            last_triangle;
  modport source(output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                 triangle_id, last_triangle, input ready);
  modport sink(input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
               triangle_id, last_triangle, output ready);
endinterface

interface rtnh_res_if import rtnh_pkg::*;;
  logic              valid;
  logic              ready;
  logic              hit;
  crd_t              dist_res;
  logic [BARY_W-1:0] bary_u;
  logic [BARY_W-1:0] bary_v;
  logic              any_hit;
  logic [ID_W-1:0]   nearest_id;
  crd_t              nearest_dist;
  logic [BARY_W-1:0] nearest_u;
  logic [BARY_W-1:0] nearest_v;
  modport source(output valid, hit, dist_res, bary_u, bary_v, any_hit, nearest_id,
                 nearest_dist, nearest_u, nearest_v, input ready);
  modport sink(input valid, hit, dist_res, bary_u, bary_v, any_hit, nearest_id,
               nearest_dist, nearest_u, nearest_v, output ready);
endinterface

// File: hdl/ray_triangle_nearest_hit.sv
// Ray/triangle intersection (Moller-Trumbore, exact) with nearest-hit tracking.
//
// cfg_i : register writes (origin, direction, t window), always ready. Write only
//         while the block is idle.
// tri_i : one triangle word per handshake; ready only while the sequencer is idle.
// res_o : one result word per triangle; held in an output register, so the next
//         triangle is taken while a result still waits.
// Datapath is bit-serial: one 33-bit x 136-bit shift-add MAC retires one
// multiplier bit per cycle, a restoring divider one quotient bit per cycle.
// Per triangle: 26 MAC terms, sign fix, two check states, three divisions and
// a result state on a hit; a miss skips the divisions, and a zero determinant
// goes from the det step straight to the result state.
// Reset: registers back to origin 0, direction +z, window [0, max]; nearest
// hit cleared. A stalled receiver holds the finished result in the sequencer
// until the output register frees up; nothing is dropped.
module ray_triangle_nearest_hit import rtnh_pkg::*; #(
  parameter int unsigned ID_BITS = ID_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtnh_cfg_if.sink    cfg_i,
  rtnh_tri_if.sink    tri_i,
  rtnh_res_if.source  res_o
);

`include "ray_triangle_nearest_hit_macros.svh"

  localparam int unsigned KEEP_W    = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int unsigned CFG_SEL_W = $clog2(NUM_REGS);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_LOAD = 9'b000000010,  // fetch MAC operands
    ST_MUL  = 9'b000000100,  // shift-add
    ST_NEG  = 9'b000001000,  // force det positive
    ST_CHK1 = 9'b000010000,  // barycentric test
    ST_CHK2 = 9'b000100000,  // distance window test
    ST_DLD  = 9'b001000000,  // divider load
    ST_DIV  = 9'b010000000,  // restoring divide
    ST_FIN  = 9'b100000000   // result word out, nearest update
  } state_e;

  state_e state_q, state_d;

  // ---------------- configuration registers ----------------
  crd_t cfg_q [NUM_REGS];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_q[i] <= '0;
      end
      cfg_q[CFG_SEL_W'(R_DIR_Z)]   <= crd_t'(1) <<< FRAC_BITS;
      cfg_q[CFG_SEL_W'(R_T_UPPER)] <= {1'b0, {(CRD_W-1){1'b1}}};
    end else if (cfg_i.valid && (cfg_i.index < CFG_IDX_W'(NUM_REGS))) begin
      cfg_q[cfg_i.index[CFG_SEL_W-1:0]] <= crd_t'(cfg_i.data);
    end
  end

  // ---------------- input capture ----------------
  logic tri_acc;
  assign tri_i.ready = (state_q == ST_IDLE);
  assign tri_acc     = tri_i.valid && tri_i.ready;

  crd_t v0 [3];
  crd_t v1 [3];
  crd_t v2 [3];
  assign v0[0] = tri_i.v0_x;
  assign v0[1] = tri_i.v0_y;
  assign v0[2] = tri_i.v0_z;
  assign v1[0] = tri_i.v1_x;
  assign v1[1] = tri_i.v1_y;
  assign v1[2] = tri_i.v1_z;
  assign v2[0] = tri_i.v2_x;
  assign v2[1] = tri_i.v2_y;
  assign v2[2] = tri_i.v2_z;

  // nar_q: dir, e1, e2, s (33 bit); wid_q: e1, e2, p, q (68 bit)
  nar_t nar_q [12];
  wid_t wid_q [12];
  big_t det_q, un_q, vn_q, tn_q, tl_q, tu_q;
  logic [KEEP_W-1:0] id_q;
  logic              last_q;

  // ---------------- bit-serial MAC ----------------
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  cnt_q;
  big_t              acc_q, mcand_q;
  nar_t              mplier_q;
  uop_t              uop_c;
  nar_t              nar_op;
  big_t              wid_op, term, acc_nx;
  logic              sub_c, mul_end;

  assign uop_c = uop_at(step_q);

  always_comb begin
    case (uop_c.nsel)
      N_TLO:   nar_op = nar_t'(cfg_q[CFG_SEL_W'(R_T_LOWER)]);
      N_THI:   nar_op = nar_t'(cfg_q[CFG_SEL_W'(R_T_UPPER)]);
      default: nar_op = nar_q[4'(uop_c.nsel)];
    endcase
  end

  always_comb begin
    case (uop_c.wsel)
      W_DET:   wid_op = det_q;
      default: wid_op = big_t'(wid_q[4'(uop_c.wsel)]);
    endcase
  end

  // sign bit of the multiplier carries negative weight
  assign mul_end = (cnt_q == CNT_W'(NW - 1));
  assign term    = mplier_q[0] ? mcand_q : '0;
  assign sub_c   = uop_c.neg ^ mul_end;
  assign acc_nx  = sub_c ? (acc_q - term) : (acc_q + term);

  // ---------------- checks ----------------
  big_t tsc, uv_sum;
  logic uv_ok_q, hit_q, t_ok;
  assign tsc    = tn_q <<< FRAC_BITS;
  assign uv_sum = un_q + vn_q;
  assign t_ok   = (tsc >= tl_q) && (tsc <= tu_q);

  // ---------------- restoring divider ----------------
  logic [1:0]       div_sel_q;
  big_t             rem_q, num_c, shl, trial, rem_nx;
  logic [CRD_W-1:0] nq_q, q_fin, q_plus;
  logic             ge, tneg_q, rem_nz;

  always_comb begin
    case (div_sel_q)
      2'd0:    num_c = un_q <<< FRAC_BITS;
      2'd1:    num_c = vn_q <<< FRAC_BITS;
      default: num_c = tsc[BW-1] ? -tsc : tsc;
    endcase
  end

  assign shl    = {rem_q[BW-2:0], nq_q[CRD_W-1]};
  assign trial  = shl - det_q;
  assign ge     = !trial[BW-1];
  assign rem_nx = ge ? trial : shl;
  assign q_fin  = {nq_q[CRD_W-2:0], ge};
  assign rem_nz = (rem_nx != '0);
  assign q_plus = q_fin + CRD_W'(rem_nz);

  crd_t              t_res_q;
  logic [BARY_W-1:0] u_res_q, v_res_q;

  // ---------------- nearest hit and output register ----------------
  logic              best_valid_q;
  logic [KEEP_W-1:0] best_id_q;
  crd_t              best_t_q;
  logic [BARY_W-1:0] best_u_q, best_v_q;
  logic              upd, fin_go, res_valid_q;

  assign fin_go = (state_q == ST_FIN) && (!res_valid_q || res_o.ready);
  assign upd    = hit_q && (!best_valid_q || (t_res_q < best_t_q));

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (tri_acc) state_d = ST_LOAD;
      ST_LOAD: begin
        if ((step_q == STEP_CHK_DET) && (det_q == '0)) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_end) begin
          if (step_q == STEP_TN_END) begin
            state_d = ST_NEG;
          end else if (step_q == STEP_TU_END) begin
            state_d = ST_CHK1;
          end else begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_NEG:  state_d = ST_LOAD;
      ST_CHK1: state_d = ST_CHK2;
      ST_CHK2: state_d = (uv_ok_q && t_ok) ? ST_DLD : ST_FIN;
      ST_DLD:  state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = (div_sel_q == 2'd2) ? ST_FIN : ST_DLD;
        end
      end
      ST_FIN:  if (fin_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      cnt_q     <= '0;
      div_sel_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          step_q    <= '0;
          div_sel_q <= '0;
        end
        ST_LOAD: cnt_q <= '0;
        ST_MUL: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (mul_end) step_q <= step_q + STEP_W'(1);
        end
        ST_DLD: cnt_q <= '0;
        ST_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) div_sel_q <= div_sel_q + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (tri_acc) begin
      for (int k = 0; k < 3; k++) begin
        nar_q[k]     <= nar_t'(cfg_q[CFG_SEL_W'(int'(R_DIR_X) + k)]);
        nar_q[3 + k] <= nar_t'(v1[k]) - nar_t'(v0[k]);
        nar_q[6 + k] <= nar_t'(v2[k]) - nar_t'(v0[k]);
        nar_q[9 + k] <= nar_t'(cfg_q[CFG_SEL_W'(int'(R_ORG_X) + k)]) - nar_t'(v0[k]);
        wid_q[k]     <= wid_t'(nar_t'(v1[k]) - nar_t'(v0[k]));
        wid_q[3 + k] <= wid_t'(nar_t'(v2[k]) - nar_t'(v0[k]));
      end
      id_q    <= tri_i.triangle_id[KEEP_W-1:0];
      last_q  <= tri_i.last_triangle;
      hit_q   <= 1'b0;
      t_res_q <= '0;
      u_res_q <= '0;
      v_res_q <= '0;
    end
    if (state_q == ST_LOAD) begin
      mcand_q  <= wid_op;
      mplier_q <= nar_op;
      if (uop_c.first) acc_q <= '0;
    end
    if (state_q == ST_MUL) begin
      acc_q    <= acc_nx;
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >>> 1;
      if (mul_end && uop_c.last) begin
        case (uop_c.dest)
          D_P0:    wid_q[6]  <= wid_t'(acc_nx);
          D_P1:    wid_q[7]  <= wid_t'(acc_nx);
          D_P2:    wid_q[8]  <= wid_t'(acc_nx);
          D_DET:   det_q     <= acc_nx;
          D_Q0:    wid_q[9]  <= wid_t'(acc_nx);
          D_Q1:    wid_q[10] <= wid_t'(acc_nx);
          D_Q2:    wid_q[11] <= wid_t'(acc_nx);
          D_UN:    un_q      <= acc_nx;
          D_VN:    vn_q      <= acc_nx;
          D_TN:    tn_q      <= acc_nx;
          D_TL:    tl_q      <= acc_nx;
          D_TU:    tu_q      <= acc_nx;
          default: ;
        endcase
      end
    end
    if ((state_q == ST_NEG) && det_q[BW-1]) begin
      det_q <= -det_q;
      un_q  <= -un_q;
      vn_q  <= -vn_q;
      tn_q  <= -tn_q;
    end
    if (state_q == ST_CHK1) begin
      uv_ok_q <= !un_q[BW-1] && !vn_q[BW-1] && (uv_sum <= det_q);
    end
    if (state_q == ST_CHK2) begin
      hit_q <= uv_ok_q && t_ok;
    end
    if (state_q == ST_DLD) begin
      rem_q <= num_c >> DIV_STEPS;
      nq_q  <= num_c[CRD_W-1:0];
      if (div_sel_q == 2'd2) tneg_q <= tsc[BW-1];
    end
    if (state_q == ST_DIV) begin
      rem_q <= rem_nx;
      nq_q  <= q_fin;
      if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
        case (div_sel_q)
          2'd0:    u_res_q <= q_fin[BARY_W-1:0];
          2'd1:    v_res_q <= q_fin[BARY_W-1:0];
          default: t_res_q <= tneg_q ? crd_t'(-q_plus) : crd_t'(q_fin);
        endcase
      end
    end
  end

  // result word fields
  logic              out_hit_q, out_any_q;
  crd_t              out_t_q, out_nt_q;
  logic [BARY_W-1:0] out_u_q, out_v_q, out_nu_q, out_nv_q;
  logic [ID_W-1:0]   out_nid_q;

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_hit_q <= hit_q;
      out_t_q   <= t_res_q;
      out_u_q   <= u_res_q;
      out_v_q   <= v_res_q;
      out_any_q <= best_valid_q || upd;
      out_nid_q <= ID_W'(upd ? id_q : best_id_q);
      out_nt_q  <= upd ? t_res_q : best_t_q;
      out_nu_q  <= upd ? u_res_q : best_u_q;
      out_nv_q  <= upd ? v_res_q : best_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q  <= 1'b0;
      best_valid_q <= 1'b0;
      best_id_q    <= '0;
      best_t_q     <= '0;
      best_u_q     <= '0;
      best_v_q     <= '0;
    end else begin
      if (fin_go) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      if (fin_go) begin
        // end of ray: forget nearest after reporting it
        if (last_q) begin
          best_valid_q <= 1'b0;
          best_id_q    <= '0;
          best_t_q     <= '0;
          best_u_q     <= '0;
          best_v_q     <= '0;
        end else if (upd) begin
          best_valid_q <= 1'b1;
          best_id_q    <= id_q;
          best_t_q     <= t_res_q;
          best_u_q     <= u_res_q;
          best_v_q     <= v_res_q;
        end
      end
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.hit          = out_hit_q;
  assign res_o.dist_res     = out_t_q;
  assign res_o.bary_u       = out_u_q;
  assign res_o.bary_v       = out_v_q;
  assign res_o.any_hit      = out_any_q;
  assign res_o.nearest_id   = out_nid_q;
  assign res_o.nearest_dist = out_nt_q;
  assign res_o.nearest_u    = out_nu_q;
  assign res_o.nearest_v    = out_nv_q;

  // ---------------- assertions ----------------
  `RTNH_ASSERT(a_acc_busy, tri_acc |=> (state_q != ST_IDLE), "accepted word left idle unset")
  `RTNH_ASSERT(a_best_clear, $fell(best_valid_q) |-> $past(last_q && fin_go), "nearest lost early")
  `RTNH_ASSERT(a_res_src, $rose(res_valid_q) |-> $past(state_q == ST_FIN), "stray result word")
  `RTNH_ASSERT_ALWAYS(a_hit_any, (res_valid_q && out_hit_q) |-> out_any_q, "hit without nearest")

endmodule
